@@ rtl/asgd_pkg.sv @@
package asgd_pkg;

  localparam int unsigned THRESH_W  = 18;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned TALLY_W   = 4;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SUM_OUT_W = 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 18;

  localparam logic [THRESH_W-1:0]  THRESH_RST  = 18'd4096;
  localparam logic [MS_W-1:0]      DEBOUNCE_RST = 16'd100;
  localparam logic [MS_W-1:0]      WINDOW_RST   = 16'd1000;
  localparam logic [TALLY_W-1:0]   NEEDED_RST   = 4'd3;
  localparam logic [SUM_OUT_W-1:0] SUM_MAX      = 18'h3FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_DEBOUNCE  = 2'd1,
    REG_WINDOW    = 2'd2,
    REG_NEEDED    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [THRESH_W-1:0] motion_threshold;
    logic [MS_W-1:0]     debounce_ms;
    logic [MS_W-1:0]     window_ms;
    logic [TALLY_W-1:0]  shakes_needed;
  } cfg_t;

endpackage

@@ rtl/asgd_lane.sv @@
module asgd_lane #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0] diff_o
);

  logic [SAMPLE_BITS-1:0] prev_q;
  logic [SAMPLE_BITS-1:0] diff_q;
  logic [SAMPLE_BITS:0]   delta;
  logic [SAMPLE_BITS:0]   mag;

  assign delta = {sample_i[SAMPLE_BITS-1], sample_i} - {prev_q[SAMPLE_BITS-1], prev_q};
  assign mag   = delta[SAMPLE_BITS] ? (~delta + 1'b1) : delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (load_i) begin
      prev_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      diff_q <= mag[SAMPLE_BITS-1:0];
    end
  end

  assign diff_o = diff_q;

endmodule

@@ rtl/asgd_merge.sv @@
module asgd_merge #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s1_valid_i,
  output logic                                 ready_o,
  input  logic [SAMPLE_BITS-1:0]               diff_x_i,
  input  logic [SAMPLE_BITS-1:0]               diff_y_i,
  input  logic [SAMPLE_BITS-1:0]               diff_z_i,
  input  logic [asgd_pkg::TIME_W-1:0]          time_i,
  input  asgd_pkg::cfg_t                       cfg_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 shake_event_o,
  output logic [asgd_pkg::SUM_OUT_W-1:0]       motion_sum_o,
  output logic [asgd_pkg::TALLY_W-1:0]         shake_tally_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + 2;
  localparam int unsigned EXT_W = (SUM_W > asgd_pkg::SUM_OUT_W) ? SUM_W : asgd_pkg::SUM_OUT_W;

  logic                             adv;
  logic [SUM_W-1:0]                 sum;
  logic [EXT_W-1:0]                 sum_ext;
  logic                             motion;
  logic                             counted;
  logic [asgd_pkg::TIME_W-1:0]      elapsed;
  logic [asgd_pkg::TALLY_W-1:0]     inc;
  logic                             event_d;
  logic [asgd_pkg::TALLY_W-1:0]     counter_d;
  logic [asgd_pkg::TIME_W-1:0]      last_d;
  logic [asgd_pkg::SUM_OUT_W-1:0]   sum_sat;

  logic                             out_valid_q;
  logic                             event_q;
  logic [asgd_pkg::SUM_OUT_W-1:0]   sum_q;
  logic [asgd_pkg::TALLY_W-1:0]     tally_q;
  logic [asgd_pkg::TALLY_W-1:0]     counter_q;
  logic [asgd_pkg::TIME_W-1:0]      last_q;

  assign ready_o = !out_valid_q || !out_stall_i;
  assign adv     = s1_valid_i && ready_o;

  assign sum     = SUM_W'(diff_x_i) + SUM_W'(diff_y_i) + SUM_W'(diff_z_i);
  assign sum_ext = EXT_W'(sum);
  assign motion  = sum_ext > EXT_W'(cfg_i.motion_threshold);
  assign elapsed = time_i - last_q;
  assign counted = motion && (elapsed > asgd_pkg::TIME_W'(cfg_i.debounce_ms));
  assign inc     = (elapsed < asgd_pkg::TIME_W'(cfg_i.window_ms)) ?
                   (counter_q + 1'b1) : asgd_pkg::TALLY_W'(1);
  assign sum_sat = (sum_ext > EXT_W'(asgd_pkg::SUM_MAX)) ?
                   asgd_pkg::SUM_MAX : sum_ext[asgd_pkg::SUM_OUT_W-1:0];

  always_comb begin
    event_d   = 1'b0;
    counter_d = counter_q;
    last_d    = last_q;
    if (counted) begin
      last_d = time_i;
      if (inc >= cfg_i.shakes_needed) begin
        counter_d = '0;
        event_d   = 1'b1;
      end else begin
        counter_d = inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      counter_q   <= '0;
      last_q      <= '0;
    end else begin
      if (ready_o) begin
        out_valid_q <= s1_valid_i;
      end
      if (adv) begin
        counter_q <= counter_d;
        last_q    <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      event_q <= event_d;
      sum_q   <= sum_sat;
      tally_q <= counter_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign shake_event_o = event_q;
  assign motion_sum_o  = sum_q;
  assign shake_tally_o = tally_q;

  a_event_clears_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && event_q |-> tally_q == '0)
    else $error("shake event with nonzero tally");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(counter_q) && $stable(last_q))
    else $error("shake state changed without an item");

  a_last_time_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && counted |=> last_q == $past(time_i))
    else $error("last shake time not captured");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q && tally_q == counter_q)
    else $error("result not loaded after advance");

endmodule

@@ rtl/accel_shake_gesture_detector_top.sv @@
// Shake gesture detector: takes one accelerometer sample per clock unless in_stall_o is set
// and returns one result per sample from the second stage's output register. Three axis lanes
// form the absolute change from the previous sample in the first stage; the second stage sums
// them, checks threshold, debounce and window against the last counted shake, and updates the
// tally. The output register lets a new sample enter while a result waits; stall from the
// output side reaches the input only once both stages hold an item. Configure only while no
// item is in flight.
module accel_shake_gesture_detector_top #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [asgd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [asgd_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [SAMPLE_BITS-1:0]             accel_x_i,
  input  logic [SAMPLE_BITS-1:0]             accel_y_i,
  input  logic [SAMPLE_BITS-1:0]             accel_z_i,
  input  logic [asgd_pkg::TIME_W-1:0]        time_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               shake_event_o,
  output logic [asgd_pkg::SUM_OUT_W-1:0]     motion_sum_o,
  output logic [asgd_pkg::TALLY_W-1:0]       shake_tally_o
);

  asgd_pkg::cfg_t                  cfg_q;
  logic                            s1_valid_q;
  logic [asgd_pkg::TIME_W-1:0]     time_q;
  logic                            merge_ready;
  logic                            accept;
  logic [SAMPLE_BITS-1:0]          diff_x;
  logic [SAMPLE_BITS-1:0]          diff_y;
  logic [SAMPLE_BITS-1:0]          diff_z;

  assign in_stall_o = s1_valid_q && !merge_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_threshold <= asgd_pkg::THRESH_RST;
      cfg_q.debounce_ms      <= asgd_pkg::DEBOUNCE_RST;
      cfg_q.window_ms        <= asgd_pkg::WINDOW_RST;
      cfg_q.shakes_needed    <= asgd_pkg::NEEDED_RST;
    end else if (cfg_we_i) begin
      unique case (asgd_pkg::cfg_reg_e'(cfg_idx_i))
        asgd_pkg::REG_THRESHOLD: cfg_q.motion_threshold <= cfg_data_i;
        asgd_pkg::REG_DEBOUNCE:  cfg_q.debounce_ms <= cfg_data_i[asgd_pkg::MS_W-1:0];
        asgd_pkg::REG_WINDOW:    cfg_q.window_ms <= cfg_data_i[asgd_pkg::MS_W-1:0];
        asgd_pkg::REG_NEEDED:    cfg_q.shakes_needed <= cfg_data_i[asgd_pkg::TALLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (merge_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      time_q <= time_ms_i;
    end
  end

  asgd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .sample_i (accel_x_i),
    .diff_o   (diff_x)
  );

  asgd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .sample_i (accel_y_i),
    .diff_o   (diff_y)
  );

  asgd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .sample_i (accel_z_i),
    .diff_o   (diff_z)
  );

  asgd_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid_q),
    .ready_o       (merge_ready),
    .diff_x_i      (diff_x),
    .diff_y_i      (diff_y),
    .diff_z_i      (diff_z),
    .time_i        (time_q),
    .cfg_i         (cfg_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .shake_event_o (shake_event_o),
    .motion_sum_o  (motion_sum_o),
    .shake_tally_o (shake_tally_o)
  );

endmodule
